// ===== rtl/kef_pkg.sv =====
// Shared definitions for the keypad event FIFO register block.
// Holds sizes, register addresses, request codes and the key-event struct.
// No dependencies.
package kef_pkg;

  // Sizes
  localparam int FIFO_DEPTH = 10;
  localparam int KEY_STRIDE = 10;
  localparam int NUM_ROWS   = 8;
  localparam int NUM_COLS   = 10;

  localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int COUNT_W = 4;
  localparam int SUM_W   = COUNT_W + 1;

  // Request kinds carried on tuser
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_KEY   = 2'd2;

  // Register addresses
  localparam logic [7:0] ADDR_CFG       = 8'h01;
  localparam logic [7:0] ADDR_INT_STAT  = 8'h02;
  localparam logic [7:0] ADDR_COUNT     = 8'h03;
  localparam logic [7:0] ADDR_POP       = 8'h04;
  localparam logic [7:0] ADDR_ROW_EN    = 8'h1D;
  localparam logic [7:0] ADDR_COL_EN_LO = 8'h1E;
  localparam logic [7:0] ADDR_COL_EN_HI = 8'h1F;

  // Bit positions and masks
  localparam int         CFG_IRQ_EN_BIT = 7;
  localparam logic [6:0] KEY_MASK       = 7'h7F;

  // Result of checking and encoding one key event
  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } key_evt_t;

endpackage

// ===== rtl/keypad_event_fifo_registers_core.sv =====
// Keypad event FIFO register block, top level.
// Depends on kef_pkg, kef_key_encode and kef_event_ram.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. tuser carries
//   the request kind (register read, register write, key event). Every input
//   word yields exactly one output word on m_tvalid/m_tready/m_tdata holding
//   the read byte (zero for writes and key events) and the interrupt line.
//   Key events that pass the row/column enables are pushed into a ten-entry
//   event store held in a synchronous RAM; a read of the pop register reads
//   the oldest entry back.
// Timing and flow:
//   Most words finish in the output register at the edge the word is accepted,
//   and a new word can be taken every cycle while the output register drains.
//   A pop from a non-empty FIFO passes through the registered RAM read port
//   and the ST_POP state before its byte reaches the output; no word is accepted in ST_POP.
// Reset (rst, synchronous): clears config, enables, interrupt flag, head and
//   count; RAM contents are not cleared and only counted entries are read.
// Stall: while the output word is held and m_tready is low, s_tready stays
//   low; the output register frees the input side as soon as it drains.
module keypad_event_fifo_registers_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: reg_addr[7:0], write_data[7:0], key_row[2:0],
  //   key_col[3:0], key_pressed
  input  logic [23:0] s_tdata,
  // s_tuser, from bit 0: req_type[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: read_data[7:0], irq_active, zero fill [6:0]
  output logic [15:0] m_tdata
);

  typedef enum logic {ST_IDLE, ST_POP} state_t;

  state_t state;

  // Register state
  logic [7:0]                  cfg_reg,      cfg_reg_next;
  logic                        key_int_flag, key_int_flag_next;
  logic [7:0]                  row_enable,   row_enable_next;
  logic [9:0]                  col_enable,   col_enable_next;
  logic [kef_pkg::PTR_W-1:0]   fifo_head,    fifo_head_next;
  logic [kef_pkg::COUNT_W-1:0] fifo_count,   fifo_count_next;

  logic                        accept;
  logic [1:0]                  req_type;
  logic [7:0]                  reg_addr;
  logic [7:0]                  write_data;
  logic [2:0]                  key_row;
  logic [3:0]                  key_col;
  logic                        key_pressed;

  kef_pkg::key_evt_t           evt;
  logic [7:0]                  rd_now;
  logic                        pop_hit;
  logic                        push;
  logic                        irq_next;
  logic [kef_pkg::SUM_W-1:0]   wr_sum;
  logic [kef_pkg::SUM_W-1:0]   wr_wrap;
  logic [kef_pkg::PTR_W-1:0]   wr_ptr;
  logic [kef_pkg::PTR_W-1:0]   head_inc;
  logic [7:0]                  ram_rdata;

  // Unpack the input word
  assign req_type    = s_tuser;
  assign reg_addr    = s_tdata[7:0];
  assign write_data  = s_tdata[15:8];
  assign key_row     = s_tdata[18:16];
  assign key_col     = s_tdata[22:19];
  assign key_pressed = s_tdata[23];

  // Take a word when idle and the output register is free or draining
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  kef_key_encode u_encode (
    .key_row     (key_row),
    .key_col     (key_col),
    .key_pressed (key_pressed),
    .row_enable  (row_enable),
    .col_enable  (col_enable),
    .evt         (evt)
  );

  // Tail pointer: head + count, wrapped once
  assign wr_sum  = kef_pkg::SUM_W'(fifo_head) + kef_pkg::SUM_W'(fifo_count);
  assign wr_wrap = (wr_sum >= kef_pkg::SUM_W'(kef_pkg::FIFO_DEPTH))
                   ? wr_sum - kef_pkg::SUM_W'(kef_pkg::FIFO_DEPTH) : wr_sum;
  assign wr_ptr  = wr_wrap[kef_pkg::PTR_W-1:0];

  assign head_inc = (fifo_head == kef_pkg::PTR_W'(kef_pkg::FIFO_DEPTH - 1))
                    ? '0 : fifo_head + 1'b1;

  // Decode the word and form the next register values
  always_comb begin
    cfg_reg_next      = cfg_reg;
    key_int_flag_next = key_int_flag;
    row_enable_next   = row_enable;
    col_enable_next   = col_enable;
    fifo_head_next    = fifo_head;
    fifo_count_next   = fifo_count;
    rd_now            = 8'd0;
    pop_hit           = 1'b0;
    push              = 1'b0;
    if (accept) begin
      unique case (req_type)
        kef_pkg::REQ_READ: begin
          unique case (reg_addr)
            kef_pkg::ADDR_CFG:       rd_now = cfg_reg;
            kef_pkg::ADDR_INT_STAT:  rd_now = {7'd0, key_int_flag};
            kef_pkg::ADDR_COUNT:     rd_now = 8'(fifo_count);
            kef_pkg::ADDR_POP: begin
              if (fifo_count != '0) begin
                pop_hit         = 1'b1;
                fifo_head_next  = head_inc;
                fifo_count_next = fifo_count - 1'b1;
              end
            end
            kef_pkg::ADDR_ROW_EN:    rd_now = row_enable;
            kef_pkg::ADDR_COL_EN_LO: rd_now = col_enable[7:0];
            kef_pkg::ADDR_COL_EN_HI: rd_now = {6'd0, col_enable[9:8]};
            default:                 rd_now = 8'd0;
          endcase
        end
        kef_pkg::REQ_WRITE: begin
          unique case (reg_addr)
            kef_pkg::ADDR_CFG:       cfg_reg_next = write_data;
            kef_pkg::ADDR_INT_STAT: begin
              if (write_data[0]) begin
                key_int_flag_next = 1'b0;
              end
            end
            kef_pkg::ADDR_ROW_EN:    row_enable_next = write_data;
            kef_pkg::ADDR_COL_EN_LO: col_enable_next = {col_enable[9:8], write_data};
            kef_pkg::ADDR_COL_EN_HI: col_enable_next = {write_data[1:0], col_enable[7:0]};
            default: ;
          endcase
        end
        kef_pkg::REQ_KEY: begin
          if (evt.hit && (fifo_count < kef_pkg::COUNT_W'(kef_pkg::FIFO_DEPTH))) begin
            push            = 1'b1;
            fifo_count_next = fifo_count + 1'b1;
            if (cfg_reg[kef_pkg::CFG_IRQ_EN_BIT]) begin
              key_int_flag_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign irq_next = key_int_flag_next && cfg_reg_next[kef_pkg::CFG_IRQ_EN_BIT];

  // Event store; a push and a pop never share an edge, and a pop issued
  // in the cycle after a push sees the written word
  kef_event_ram u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata (evt.code),
    .re    (pop_hit),
    .raddr (fifo_head),
    .rdata (ram_rdata)
  );

  // Hold the register state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg      <= 8'd0;
      key_int_flag <= 1'b0;
      row_enable   <= 8'd0;
      col_enable   <= 10'd0;
      fifo_head    <= '0;
      fifo_count   <= '0;
    end else begin
      cfg_reg      <= cfg_reg_next;
      key_int_flag <= key_int_flag_next;
      row_enable   <= row_enable_next;
      col_enable   <= col_enable_next;
      fifo_head    <= fifo_head_next;
      fifo_count   <= fifo_count_next;
    end
  end

  // Sequence the pop and drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            m_tdata[15:8] <= {7'd0, irq_next};
            if (pop_hit) begin
              state <= ST_POP;
            end else begin
              m_tdata[7:0] <= rd_now;
              m_tvalid     <= 1'b1;
            end
          end
        end
        ST_POP: begin
          m_tdata[7:0] <= ram_rdata;
          m_tvalid     <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> !m_tvalid)
    else $error("pop data would overwrite a pending output word");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= kef_pkg::COUNT_W'(kef_pkg::FIFO_DEPTH))
    else $error("event count above FIFO depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_head < kef_pkg::PTR_W'(kef_pkg::FIFO_DEPTH - 1) + 1'b1
    || kef_pkg::FIFO_DEPTH == (1 << kef_pkg::PTR_W))
    else $error("head pointer out of range");

  a_pop_sequence: assert property (@(posedge clk) disable iff (rst)
    pop_hit |=> (state == ST_POP) && (fifo_count == $past(fifo_count) - 1'b1))
    else $error("pop did not enter the read cycle or update the count");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> m_tvalid && (state == ST_IDLE))
    else $error("pop result not delivered after the read cycle");

endmodule

// ===== rtl/kef_event_ram.sv =====
// Event store: synchronous memory, one write port and one registered read port.
// Depends on kef_pkg for depth and pointer width.
module kef_event_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [kef_pkg::PTR_W-1:0] waddr,
  input  logic [7:0]              wdata,
  input  logic                    re,
  input  logic [kef_pkg::PTR_W-1:0] raddr,
  output logic [7:0]              rdata
);

  logic [7:0] mem [kef_pkg::FIFO_DEPTH];

  // Write the pushed event
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/kef_key_encode.sv =====
// Key event check and encode: row/column range and enable test, event byte.
// Depends on kef_pkg for sizes and the key_evt_t struct.
module kef_key_encode (
  input  logic [2:0]        key_row,
  input  logic [3:0]        key_col,
  input  logic              key_pressed,
  input  logic [7:0]        row_enable,
  input  logic [9:0]        col_enable,
  output kef_pkg::key_evt_t evt
);

  logic       row_ok;
  logic       col_ok;
  logic [7:0] key_num;

  // Accept only rows and columns in range whose enable bit is set
  assign row_ok = (key_row < 3'(kef_pkg::NUM_ROWS - 1) + 3'd1 || kef_pkg::NUM_ROWS == 8)
                  && row_enable[key_row];
  assign col_ok = (key_col < 4'(kef_pkg::NUM_COLS)) && col_enable[key_col];

  // Key number: row * stride + col + 1, kept to seven bits
  assign key_num = 8'({5'd0, key_row} * 8'(kef_pkg::KEY_STRIDE)) + {4'd0, key_col} + 8'd1;

  assign evt.hit  = row_ok && col_ok;
  assign evt.code = {key_pressed, key_num[6:0] & kef_pkg::KEY_MASK};

endmodule
